@@ rtl/core/scu_pkg.sv @@
// Shared types, formats and fixed-point helpers of the sine/cosine unit.
// No dependencies; every other file of the unit imports this package.
package scu_pkg;

   localparam int ANGLE_W          = 32;
   localparam int ANGLE_FRAC_BITS  = 24;
   localparam int RESULT_W         = 32;
   localparam int RESULT_FRAC_BITS = 30;

   // internal formats: wide angle Q.38, working values unsigned Q.30
   localparam int WORK_BITS = 30;
   localparam int WIDE_BITS = 38;
   localparam int WORK_W    = WORK_BITS + 1;

   localparam int ANGLE_SHIFT = WIDE_BITS - ANGLE_FRAC_BITS;
   localparam int MAG_W       = ANGLE_W + ANGLE_SHIFT;
   localparam int WIDE_W      = MAG_W + 1;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
   localparam int          PI_SHIFT    = 62 - WIDE_BITS;
   localparam logic [63:0] HALF_PI_W   =
      (HALF_PI_Q62 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT;
   localparam logic [63:0] PI16_W      =
      (HALF_PI_Q62 + (64'd1 << (PI_SHIFT + 2))) >> (PI_SHIFT + 3);
   localparam int          REM_W       = $clog2(HALF_PI_W + 64'd1);
   localparam int          QUOT_W      = MAG_W - REM_W + 1;
   localparam logic [63:0] SMALL_W     = 64'd1 << (WIDE_BITS - 7);
   localparam int          TO_WORK_SHIFT = WIDE_BITS - WORK_BITS;

   localparam logic [WORK_W-1:0] ONE_Q = WORK_W'(64'd1 << WORK_BITS);

   localparam int PROD_W = 2 * WORK_W + 1;
   localparam logic [PROD_W-1:0] QMUL_ROUND = PROD_W'(64'd1 << (WORK_BITS - 1));

   // floor division by a constant: ceil(2^s/d) reciprocal, exact for WORK_W-bit inputs
   localparam int DIV_N   = WORK_W;
   localparam int DIVM_W  = DIV_N + 2;
   localparam int DPROD_W = WORK_W + DIVM_W;
   localparam int DIV6_S  = DIV_N + 3;
   localparam int DIV20_S = DIV_N + 5;
   localparam int DIV42_S = DIV_N + 6;
   localparam int DIV72_S = DIV_N + 7;
   localparam logic [DIVM_W-1:0] DIV6_M  = DIVM_W'(((64'd1 << DIV6_S) + 64'd5) / 64'd6);
   localparam logic [DIVM_W-1:0] DIV20_M = DIVM_W'(((64'd1 << DIV20_S) + 64'd19) / 64'd20);
   localparam logic [DIVM_W-1:0] DIV42_M = DIVM_W'(((64'd1 << DIV42_S) + 64'd41) / 64'd42);
   localparam logic [DIVM_W-1:0] DIV72_M = DIVM_W'(((64'd1 << DIV72_S) + 64'd71) / 64'd72);

   localparam int ROOT_W = WORK_W;
   localparam int RAD_W  = 2 * WORK_W;

   localparam int RES_SHIFT = WORK_BITS - RESULT_FRAC_BITS;
   localparam logic [WORK_W:0] RES_ROUND = (WORK_W + 1)'((64'd1 << RES_SHIFT) >> 1);
   localparam logic [WORK_W:0] RES_ONE   = (WORK_W + 1)'(64'd1 << RESULT_FRAC_BITS);

   typedef struct packed {
      logic       valid;
      logic       neg;
      logic       small_ang;
      logic [1:0] depth;
   } scu_ctl_type;

   typedef struct packed {
      scu_ctl_type       ctl;
      logic [WORK_W-1:0] sv;
      logic [WORK_W-1:0] sq;
   } scu_side_type;

   function automatic logic [WORK_W-1:0] qmul(input logic [WORK_W-1:0] a,
                                              input logic [WORK_W-1:0] b);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(a) * PROD_W'(b) + QMUL_ROUND;
      return WORK_W'(prod >> WORK_BITS);
   endfunction

   function automatic logic [WORK_W-1:0] div_const(input logic [WORK_W-1:0] x,
                                                   input logic [DIVM_W-1:0] m,
                                                   input int s);
      logic [DPROD_W-1:0] prod;
      prod = DPROD_W'(x) * DPROD_W'(m);
      return WORK_W'(prod >> s);
   endfunction

endpackage

@@ rtl/core/scu_if.sv @@
// Request and response channel interfaces of the sine/cosine unit.
// Depends on scu_pkg for the field widths.
interface scu_req_if import scu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle;
   logic                      mode;

   modport source (output valid, output angle, output mode, input ready);
   modport sink   (input valid, input angle, input mode, output ready);
endinterface

interface scu_rsp_if import scu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

@@ rtl/core/scu_reduce.sv @@
// Angle front end: widening, cosine offset, sign fold, pipelined reduction
// modulo pi/2, quadrant mirror and quartering. Depends on scu_pkg.
module scu_reduce import scu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [ANGLE_W-1:0] in_angle,
   input  logic                      in_mode,
   output scu_ctl_type               out_ctl,
   output logic [WORK_W-1:0]         out_x
);

   typedef struct packed {
      logic                     valid;
      logic signed [WIDE_W-1:0] wide;
   } scu_wide_type;

   typedef struct packed {
      scu_ctl_type      ctl;
      logic [MAG_W-1:0] rem;
      logic [1:0]       quad;
   } scu_div_type;

   typedef struct packed {
      scu_ctl_type      ctl;
      logic [REM_W-1:0] rem;
   } scu_fold_type;

   localparam logic signed [WIDE_W-1:0] HALF_PI_S = WIDE_W'(HALF_PI_W);

   scu_wide_type      wide_ff, wide_in;
   scu_div_type       div_ff [0:QUOT_W];
   scu_div_type       div_in [0:QUOT_W];
   scu_fold_type      fold_ff [0:2];
   scu_fold_type      fold_in [0:2];
   scu_ctl_type       ctl_ff, ctl_in;
   logic [WORK_W-1:0] x_ff, x_in;

   always_comb begin
      logic signed [WIDE_W-1:0] ext;
      logic                     neg;
      logic [MAG_W-1:0]         mag;
      logic [MAG_W-1:0]         step;
      logic                     hit;

      ext = WIDE_W'(in_angle) <<< ANGLE_SHIFT;
      wide_in.valid = in_valid;
      wide_in.wide  = in_mode ? HALF_PI_S - ext : ext;

      neg = wide_ff.wide[WIDE_W-1];
      mag = neg ? MAG_W'(-wide_ff.wide) : MAG_W'(wide_ff.wide);
      div_in[0].ctl.valid     = wide_ff.valid;
      div_in[0].ctl.neg       = neg;
      div_in[0].ctl.small_ang = 64'(mag) < SMALL_W;
      div_in[0].ctl.depth     = 2'd0;
      div_in[0].rem           = mag;
      div_in[0].quad          = 2'd0;

      // restoring division, one quotient bit per stage; keep the low two bits
      for (int k = 0; k < QUOT_W; k++) begin
         step = MAG_W'(HALF_PI_W << (QUOT_W - 1 - k));
         hit  = div_ff[k].rem >= step;
         div_in[k+1] = div_ff[k];
         if (hit) begin
            div_in[k+1].rem = div_ff[k].rem - step;
         end
         div_in[k+1].quad = {div_ff[k].quad[0], hit};
      end

      fold_in[0].ctl = div_ff[QUOT_W].ctl;
      fold_in[0].rem = REM_W'(div_ff[QUOT_W].rem);
      if (!div_ff[QUOT_W].ctl.small_ang) begin
         fold_in[0].ctl.neg = div_ff[QUOT_W].ctl.neg ^ div_ff[QUOT_W].quad[1];
         if (div_ff[QUOT_W].quad[0]) begin
            fold_in[0].rem = REM_W'(HALF_PI_W) - REM_W'(div_ff[QUOT_W].rem);
         end
      end

      for (int k = 1; k < 3; k++) begin
         fold_in[k] = fold_ff[k-1];
         if (64'(fold_ff[k-1].rem) > PI16_W) begin
            fold_in[k].rem = REM_W'(({1'b0, fold_ff[k-1].rem} + (REM_W + 1)'(2)) >> 2);
            fold_in[k].ctl.depth = fold_ff[k-1].ctl.depth + 2'd1;
         end
      end

      ctl_in = fold_ff[2].ctl;
      x_in   = WORK_W'(({1'b0, fold_ff[2].rem}
                        + (REM_W + 1)'(64'd1 << (TO_WORK_SHIFT - 1))) >> TO_WORK_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff.valid <= 1'b0;
         for (int k = 0; k <= QUOT_W; k++) begin
            div_ff[k].ctl.valid <= 1'b0;
         end
         for (int k = 0; k < 3; k++) begin
            fold_ff[k].ctl.valid <= 1'b0;
         end
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         wide_ff <= wide_in;
         div_ff  <= div_in;
         fold_ff <= fold_in;
         ctl_ff  <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;

endmodule

@@ rtl/core/scu_series.sv @@
// Odd power series for the sine of the reduced angle, one multiply per stage.
// Small angles drop the two high terms. Depends on scu_pkg.
module scu_series import scu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  scu_ctl_type       in_ctl,
   input  logic [WORK_W-1:0] in_x,
   output scu_ctl_type       out_ctl,
   output logic [WORK_W-1:0] out_val
);

   typedef struct packed {
      scu_ctl_type       ctl;
      logic [WORK_W-1:0] x;
      logic [WORK_W-1:0] r2;
      logic [WORK_W-1:0] acc;
   } scu_ser_type;

   scu_ser_type st_ff [0:8];
   scu_ser_type st_in [0:8];

   always_comb begin
      st_in[0].ctl = in_ctl;
      st_in[0].x   = in_x;
      st_in[0].r2  = qmul(in_x, in_x);
      st_in[0].acc = '0;

      for (int k = 1; k < 9; k++) begin
         st_in[k] = st_ff[k-1];
      end

      st_in[1].acc = div_const(st_ff[0].r2, DIV72_M, DIV72_S);
      st_in[2].acc = qmul(st_ff[1].r2, ONE_Q - st_ff[1].acc);
      st_in[3].acc = div_const(st_ff[2].acc, DIV42_M, DIV42_S);
      // small angles start the series here, from the square itself
      st_in[4].acc = st_ff[3].ctl.small_ang ? st_ff[3].r2
                                            : qmul(st_ff[3].r2, ONE_Q - st_ff[3].acc);
      st_in[5].acc = div_const(st_ff[4].acc, DIV20_M, DIV20_S);
      st_in[6].acc = qmul(st_ff[5].r2, ONE_Q - st_ff[5].acc);
      st_in[7].acc = div_const(st_ff[6].acc, DIV6_M, DIV6_S);
      st_in[8].acc = qmul(st_ff[7].x, ONE_Q - st_ff[7].acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            st_ff[k].ctl.valid <= 1'b0;
         end
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_ctl = st_ff[8].ctl;
   assign out_val = st_ff[8].acc;

endmodule

@@ rtl/core/scu_root.sv @@
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. Depends on scu_pkg.
module scu_root import scu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  scu_side_type      in_side,
   input  logic [RAD_W-1:0]  in_rad,
   output scu_side_type      out_side,
   output logic [ROOT_W-1:0] out_root
);

   typedef struct packed {
      scu_side_type      side;
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } scu_rstage_type;

   scu_rstage_type st_ff [0:ROOT_W-1];
   scu_rstage_type st_in [0:ROOT_W-1];

   // try bit i: (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
   function automatic scu_rstage_type root_step(input scu_rstage_type s, input int i);
      scu_rstage_type   r;
      logic [RAD_W:0]   trial;
      r     = s;
      trial = ((RAD_W + 1)'(s.root) << (i + 1)) + ((RAD_W + 1)'(1) << (2 * i));
      if ({1'b0, s.rem} >= trial) begin
         r.rem  = s.rem - RAD_W'(trial);
         r.root = s.root | (ROOT_W'(1) << i);
      end
      return r;
   endfunction

   always_comb begin
      scu_rstage_type first;
      first.side = in_side;
      first.rem  = in_rad;
      first.root = '0;
      st_in[0] = root_step(first, ROOT_W - 1);
      for (int k = 1; k < ROOT_W; k++) begin
         st_in[k] = root_step(st_ff[k-1], ROOT_W - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            st_ff[k].side.ctl.valid <= 1'b0;
         end
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_side = st_ff[ROOT_W-1].side;
   assign out_root = st_ff[ROOT_W-1].root;

endmodule

@@ rtl/core/scu_quad.sv @@
// One quadruple-angle rebuild: sin4t = 4s*sqrt(1-s^2)*(1-2s^2), applied when
// the item still has quarterings to undo. Depends on scu_pkg and scu_root.
module scu_quad import scu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  scu_ctl_type       in_ctl,
   input  logic [WORK_W-1:0] in_val,
   output scu_ctl_type       out_ctl,
   output logic [WORK_W-1:0] out_val
);

   typedef struct packed {
      scu_ctl_type       ctl;
      logic [WORK_W-1:0] sv;
      logic [WORK_W-1:0] p;
      logic [WORK_W-1:0] k;
      logic              zero;
   } scu_mid_type;

   typedef struct packed {
      scu_ctl_type       ctl;
      logic [WORK_W-1:0] val;
   } scu_qout_type;

   scu_side_type      side_ff, side_in;
   scu_side_type      root_side;
   logic [ROOT_W-1:0] root;
   logic [RAD_W-1:0]  rad;
   scu_mid_type       mid_ff, mid_in;
   scu_qout_type      res_ff, res_in;

   always_comb begin
      logic [WORK_W-1:0] sv;
      sv = (in_ctl.depth != 2'd0 && in_val > ONE_Q) ? ONE_Q : in_val;
      side_in.ctl = in_ctl;
      side_in.sv  = sv;
      side_in.sq  = qmul(sv, sv);
   end

   assign rad = RAD_W'(ONE_Q - side_ff.sq) << WORK_BITS;

   scu_root u_root (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (side_ff),
      .in_rad   (rad),
      .out_side (root_side),
      .out_root (root)
   );

   always_comb begin
      logic [WORK_W:0] twosq;
      twosq       = {root_side.sq, 1'b0};
      mid_in.ctl  = root_side.ctl;
      mid_in.sv   = root_side.sv;
      mid_in.p    = qmul(root_side.sv, root);
      mid_in.zero = twosq > {1'b0, ONE_Q};
      mid_in.k    = ONE_Q - WORK_W'(twosq);
   end

   always_comb begin
      logic [WORK_W+1:0] v4;
      v4 = {qmul(mid_ff.p, mid_ff.k), 2'b00};
      res_in.ctl = mid_ff.ctl;
      if (mid_ff.ctl.depth == 2'd0) begin
         res_in.val = mid_ff.sv;
      end else begin
         res_in.ctl.depth = mid_ff.ctl.depth - 2'd1;
         if (mid_ff.zero) begin
            res_in.val = '0;
         end else if (v4 > (WORK_W + 2)'(ONE_Q)) begin
            res_in.val = ONE_Q;
         end else begin
            res_in.val = WORK_W'(v4);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.ctl.valid <= 1'b0;
         mid_ff.ctl.valid  <= 1'b0;
         res_ff.ctl.valid  <= 1'b0;
      end else if (en) begin
         side_ff <= side_in;
         mid_ff  <= mid_in;
         res_ff  <= res_in;
      end
   end

   assign out_ctl = res_ff.ctl;
   assign out_val = res_ff.val;

endmodule

@@ rtl/core/sine_cosine_unit.sv @@
// Fixed-point sine/cosine unit.
//
// Requests arrive on req_ch: angle in radians (signed, 24 fraction bits) and
// mode (0 sine, 1 cosine). Each request yields one response on rsp_ch: the
// value as signed Q1.30, saturated to plus or minus one.
// Both channels move an item when valid and ready are high at a clock edge.
// The datapath is a single pipeline: range reduction with a restoring divider
// (one quotient bit per stage), a nine-stage series, and two rebuild stages
// whose 31-stage square roots dominate the depth. A new request is taken
// every cycle while req_ch.ready is high.
// When rsp_ch stalls, the output register holds its response and one more
// response lands in a skid register; only then does the pipeline freeze and
// req_ch.ready fall. It rises again the cycle after the skid drains.
// Synchronous reset empties the pipeline and both output registers.
// Depends on scu_pkg, scu_if and the scu_* submodules.
module sine_cosine_unit import scu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   scu_req_if.sink   req_ch,
   scu_rsp_if.source rsp_ch
);

   typedef struct packed {
      logic                       valid;
      logic signed [RESULT_W-1:0] result;
   } scu_fin_type;

   logic                       en;
   scu_ctl_type                red_ctl, ser_ctl, q1_ctl, q2_ctl;
   logic [WORK_W-1:0]          red_x, ser_val, q1_val, q2_val;
   scu_fin_type                fin_ff, fin_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [RESULT_W-1:0] out_result_ff, out_result_in;
   logic                       skid_valid_ff, skid_valid_in;
   logic signed [RESULT_W-1:0] skid_result_ff, skid_result_in;

   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   scu_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .in_angle (req_ch.angle),
      .in_mode  (req_ch.mode),
      .out_ctl  (red_ctl),
      .out_x    (red_x)
   );

   scu_series u_series (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (red_ctl),
      .in_x    (red_x),
      .out_ctl (ser_ctl),
      .out_val (ser_val)
   );

   scu_quad u_quad_0 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (ser_ctl),
      .in_val  (ser_val),
      .out_ctl (q1_ctl),
      .out_val (q1_val)
   );

   scu_quad u_quad_1 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (q1_ctl),
      .in_val  (q1_val),
      .out_ctl (q2_ctl),
      .out_val (q2_val)
   );

   // round to the result format, saturate, put the sign back
   always_comb begin
      logic [WORK_W:0] rnd;
      logic [WORK_W:0] sat;
      rnd = ({1'b0, q2_val} + RES_ROUND) >> RES_SHIFT;
      sat = (rnd > RES_ONE) ? RES_ONE : rnd;
      fin_in.valid  = q2_ctl.valid;
      fin_in.result = q2_ctl.neg ? -RESULT_W'(sat) : RESULT_W'(sat);
   end

   always_comb begin
      logic pop;
      pop            = out_valid_ff && rsp_ch.ready;
      out_valid_in   = out_valid_ff && !pop;
      out_result_in  = out_result_ff;
      skid_valid_in  = skid_valid_ff;
      skid_result_in = skid_result_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_valid_in  = 1'b1;
            out_result_in = skid_result_ff;
            skid_valid_in = 1'b0;
         end
      end else if (fin_ff.valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_in  = 1'b1;
            out_result_in = fin_ff.result;
         end else begin
            skid_valid_in  = 1'b1;
            skid_result_in = fin_ff.result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.valid  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            fin_ff <= fin_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_result_ff  <= out_result_in;
      skid_result_ff <= skid_result_in;
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.result = out_result_ff;

endmodule

@@ dv/sine_cosine_unit_tb.sv @@
// Testbench of the sine/cosine unit: directed table, then random requests.
// Predicts each response from its own fixed-point model, unless the table row
// gives a typed-in value, and checks in order. Depends on scu_pkg, scu_if and the sine_cosine_unit RTL.
`timescale 1ns / 100ps

module sine_cosine_unit_tb;
   import scu_pkg::*;

   localparam int IDLE_MAX   = 7;
   localparam int LATENCY    = 93;
   localparam int STALL_LIM  = 4000;
   localparam int N_RANDOM   = 700;

   typedef struct {
      logic signed [31:0] angle;
      logic               mode;
      logic               has_val;
      logic signed [31:0] val;
   } stim_row_type;

   localparam logic [63:0] HP_W   = 64'h6487_ED51_10B4_611A + (64'd1 << 23) >> 24;
   localparam logic [63:0] P16_W  = 64'h6487_ED51_10B4_611A + (64'd1 << 26) >> 27;
   localparam logic [63:0] ONE30  = 64'd1 << 30;
   localparam logic [63:0] HP_ANG = (64'h6487_ED51_10B4_611A + (64'd1 << 37)) >> 38;

   logic clock;
   logic reset;
   bit   failed;
   int   stall_cnt;
   logic signed [31:0] expected_vals[$];
   bit   stim_done;

   scu_req_if req_ch ();
   scu_rsp_if rsp_ch ();

   sine_cosine_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] rebuild_sine(logic [63:0] s);
      logic [63:0] sq;
      logic [63:0] rt;
      logic [63:0] p;
      logic [63:0] v;
      if (s > ONE30) s = ONE30;
      sq = fx_mul(s, s);
      rt = isqrt((ONE30 - sq) << 30);
      p  = fx_mul(s, rt);
      if (2 * sq > ONE30) return 0;
      v = fx_mul(p, ONE30 - 2 * sq) * 4;
      if (v > ONE30) v = ONE30;
      return v;
   endfunction

   function automatic logic signed [31:0] predict_trig(logic signed [31:0] angle,
                                                      logic mode);
      logic signed [63:0] w;
      logic [63:0] mag;
      logic [63:0] val;
      logic [63:0] a30;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] quad;
      logic [63:0] rem;
      bit neg;
      int depth;
      w = 64'(angle) <<< 14;
      if (mode) w = $signed(HP_W) - w;
      neg = w < 0;
      mag = neg ? -w : w;
      if (mag < (64'd1 << 31)) begin
         a30 = (mag + 64'd128) >> 8;
         a2  = fx_mul(a30, a30);
         t   = ONE30 - a2 / 20;
         t   = ONE30 - fx_mul(a2, t) / 6;
         val = fx_mul(a30, t);
      end else begin
         quad = mag / HP_W;
         rem  = mag - quad * HP_W;
         if (quad[1]) neg = !neg;
         if (quad[0]) rem = HP_W - rem;
         depth = 0;
         while (depth < 2 && rem > P16_W) begin
            rem = (rem + 2) >> 2;
            depth++;
         end
         a30 = (rem + 64'd128) >> 8;
         a2  = fx_mul(a30, a30);
         t   = ONE30 - a2 / 72;
         t   = ONE30 - fx_mul(a2, t) / 42;
         t   = ONE30 - fx_mul(a2, t) / 20;
         t   = ONE30 - fx_mul(a2, t) / 6;
         val = fx_mul(a30, t);
         for (int d = 0; d < depth; d++) val = rebuild_sine(val);
      end
      if (val > ONE30) val = ONE30;
      return neg ? -val[31:0] : val[31:0];
   endfunction

   // directed rows; only the first gives a typed-in value (zero), the rest use the model
   stim_row_type stim_table[] = '{
      '{32'sd0,          1'b0, 1'b1, 32'sd0},
      '{32'sd0,          1'b1, 1'b0, 32'sd0},
      '{32'h7FFF_FFFF,   1'b0, 1'b0, 32'sd0},
      '{32'h7FFF_FFFF,   1'b1, 1'b0, 32'sd0},
      '{32'h8000_0000,   1'b0, 1'b0, 32'sd0},
      '{32'h8000_0000,   1'b1, 1'b0, 32'sd0},
      '{32'sd1,          1'b0, 1'b0, 32'sd0},
      '{-32'sd1,         1'b0, 1'b0, 32'sd0},
      '{32'sd131071,     1'b0, 1'b0, 32'sd0},
      '{32'sd131072,     1'b0, 1'b0, 32'sd0},
      '{-32'sd131072,    1'b1, 1'b0, 32'sd0},
      '{32'(HP_ANG),     1'b0, 1'b0, 32'sd0},
      '{32'(HP_ANG),     1'b1, 1'b0, 32'sd0},
      '{32'(2 * HP_ANG), 1'b0, 1'b0, 32'sd0},
      '{32'(3 * HP_ANG), 1'b1, 1'b0, 32'sd0},
      '{32'(HP_ANG / 8), 1'b0, 1'b0, 32'sd0},
      '{32'(HP_ANG / 8 + 1), 1'b0, 1'b0, 32'sd0},
      '{32'(HP_ANG / 2), 1'b0, 1'b0, 32'sd0},
      '{32'(HP_ANG - 1), 1'b0, 1'b0, 32'sd0},
      '{32'sd13176795,   1'b0, 1'b0, 32'sd0},
      '{-32'sd26353590,  1'b1, 1'b0, 32'sd0},
      '{32'h5555_5555,   1'b0, 1'b0, 32'sd0},
      '{32'hAAAA_AAAA,   1'b1, 1'b0, 32'sd0}
   };

   // drop valid only for an idle gap; back-to-back requests keep it high
   task automatic send_request(logic signed [31:0] angle, logic mode,
                               bit has_val, logic signed [31:0] val);
      int gap;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.angle <= angle;
      req_ch.mode  <= mode;
      expected_vals.push_back(has_val ? val : predict_trig(angle, mode));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      logic signed [31:0] ang;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.angle = '0;
      req_ch.mode  = 1'b0;
      stim_done    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_table[i])
         send_request(stim_table[i].angle, stim_table[i].mode,
                      stim_table[i].has_val, stim_table[i].val);
      for (int n = 0; n < N_RANDOM; n++) begin
         case ($urandom_range(0, 3))
            0: ang = $urandom;
            1: ang = $signed($urandom_range(0, 32'h0640_0000)) - 32'sh0320_0000;
            2: ang = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: ang = $signed($urandom_range(0, 32'h7FFF_FFFF))
                           * ($urandom_range(0, 1) ? 1 : -1);
         endcase
         send_request(ang, 1'($urandom_range(0, 1)), 1'b0, 32'sd0);
      end
      req_ch.valid <= 1'b0;
      stim_done    <= 1'b1;
   end

   // response side: random stall, then check against the oldest expectation
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX));
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (expected_vals.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h",
                     $time, rsp_ch.result);
            failed = 1'b1;
         end else begin
            logic signed [31:0] exp_val;
            exp_val = expected_vals.pop_front();
            if (rsp_ch.result !== exp_val) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, exp_val, rsp_ch.result);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog and end of run
   initial begin
      stall_cnt = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cnt = 0;
         else
            stall_cnt++;
         if (stall_cnt >= STALL_LIM) begin
            $display("status: fail");
            $finish;
         end
         if (stim_done && expected_vals.size() == 0) begin
            repeat (LATENCY + 20) @(posedge clock);
            if (!failed && expected_vals.size() == 0) begin
               $display("status: pass");
            end else begin
               $display("status: fail");
            end
            $finish;
         end
      end
   end

endmodule

@@ files.f @@
rtl/core/scu_pkg.sv
rtl/core/scu_if.sv
rtl/core/scu_reduce.sv
rtl/core/scu_series.sv
rtl/core/scu_root.sv
rtl/core/scu_quad.sv
rtl/core/sine_cosine_unit.sv
dv/sine_cosine_unit_tb.sv
